// File: hdl/twc_pkg.sv
package twc_pkg;

   // Command codes carried on the request channel.
   localparam logic [1:0] CMD_BYTE = 2'd0;
   localparam logic [1:0] CMD_V4   = 2'd1;
   localparam logic [1:0] CMD_V6   = 2'd2;
   localparam logic [1:0] CMD_PORT = 2'd3;

   // Parser phases.
   localparam logic [2:0] PH_ETH  = 3'd0;
   localparam logic [2:0] PH_V4   = 3'd1;
   localparam logic [2:0] PH_V6   = 3'd2;
   localparam logic [2:0] PH_TCP  = 3'd3;
   localparam logic [2:0] PH_PASS = 3'd4;

   localparam logic [15:0] KIND_V4   = 16'h0800;
   localparam logic [15:0] KIND_V6   = 16'h86DD;
   localparam logic [7:0]  PROTO_TCP = 8'd6;
   localparam logic [15:0] PORT_HTTP  = 16'd80;
   localparam logic [15:0] PORT_HTTPS = 16'd443;
   localparam logic [6:0]  MIN_HDR   = 7'd20;
   localparam logic [3:0]  MIN_DOFF  = 4'd5;
   localparam logic [5:0]  V6_HDR    = 6'd40;
   localparam logic [4:0]  ETH_HDR   = 5'd14;

   // Register indexes.
   localparam logic [0:0] REG_PORT_COUNT = 1'd0;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  byte_value;
      logic        frame_end;
      logic [15:0] frame_length;
      logic [5:0]  entry_index;
      logic [63:0] address_high;
      logic [63:0] address_low;
      logic [7:0]  block_value;
      logic [15:0] port_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_end;
      logic       clamped;
   } rsp_type;

   // Table write broadcast to every cell.
   typedef struct packed {
      logic        wr_v4;
      logic        wr_v6;
      logic        wr_port;
      logic [5:0]  index;
      logic        valid;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [15:0] port;
   } tbl_wr_type;

   // Lookup key presented to every cell.
   typedef struct packed {
      logic        is_v4;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [15:0] port;
   } key_type;

endpackage

// File: hdl/tcp_window_clamp_filter.sv
// Channel  | Direction | Handshake           | Payload
// req      | in        | req_valid/req_ready | twc_pkg::req_type
// rsp      | out       | rsp_valid/rsp_ready | twc_pkg::rsp_type
// csr      | in        | APB, pready high    | port_count at address 0
//
// One word per cycle unless the output stalls; a byte's result is registered.
// Table writes give no result. The parser, the blocklist cells and the port cells
// compare in parallel; a registered match flag per table settles before the
// first window byte. Reset is synchronous and empties all tables. A stalled
// output register holds its word, and the input waits only while it is full.
module tcp_window_clamp_filter #(
   parameter int BLOCK_ENTRIES = 64,
   parameter int PORT_SLOTS    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  twc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output twc_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [3:0] port_count_ff;
   logic       take;
   logic       is_byte;

   // Configuration register.
   assign pready = 1'b1;
   assign prdata = (paddr[2] == twc_pkg::REG_PORT_COUNT) ? {28'd0, port_count_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) port_count_ff <= 4'd0;
      else if (psel && penable && pwrite && paddr[2] == twc_pkg::REG_PORT_COUNT)
         port_count_ff <= pwdata[3:0];
   end

   // Output register handshake.
   logic            rsp_valid_ff;
   twc_pkg::rsp_type rsp_ff;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;
   assign is_byte   = req_data.command == twc_pkg::CMD_BYTE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Table write word to the cells.
   twc_pkg::tbl_wr_type wr;
   always_comb begin
      wr.wr_v4   = take && req_data.command == twc_pkg::CMD_V4;
      wr.wr_v6   = take && req_data.command == twc_pkg::CMD_V6;
      wr.wr_port = take && req_data.command == twc_pkg::CMD_PORT;
      wr.index   = req_data.entry_index;
      wr.valid   = req_data.block_value != 8'd0;
      wr.addr_hi = req_data.address_high;
      wr.addr_lo = req_data.address_low;
      wr.port    = req_data.port_value;
   end

   // Parser state.
   logic [15:0] off_ff;
   logic [2:0]  phase_ff;
   logic [15:0] kind_ff;
   logic [5:0]  iph_ff;
   logic [7:0]  proto_ff;
   logic [3:0]  doff_ff;
   logic [63:0] ahi_ff, alo_ff;
   logic [15:0] dport_ff;
   logic        clamp_ff;
   logic        ahit_ff, phit_ff;

   twc_pkg::key_type key;
   assign key.is_v4   = kind_ff == twc_pkg::KIND_V4;
   assign key.addr_hi = ahi_ff;
   assign key.addr_lo = alo_ff;
   assign key.port    = dport_ff;

   // Blocklist chain.
   logic [BLOCK_ENTRIES:0] bchain;
   assign bchain[0] = 1'b0;
   for (genvar g = 0; g < BLOCK_ENTRIES; g++) begin : g_blk
      twc_block_cell #(.SLOT(g), .IW(6)) u_cell (
         .clock(clock), .reset(reset), .wr(wr), .key(key),
         .hit_prev(bchain[g]), .hit_next(bchain[g+1]));
   end

   // Port chain.
   logic [PORT_SLOTS:0] pchain;
   assign pchain[0] = 1'b0;
   for (genvar g = 0; g < PORT_SLOTS; g++) begin : g_port
      twc_port_cell #(.SLOT(g)) u_cell (
         .clock(clock), .reset(reset), .wr(wr), .key(key), .port_count(port_count_ff),
         .hit_prev(pchain[g]), .hit_next(pchain[g+1]));
   end

   // Registered match flags; the key is stable well before the window bytes.
   logic port_hit_in;
   always_comb begin
      if (port_count_ff == 4'd0)
         port_hit_in = dport_ff == twc_pkg::PORT_HTTP || dport_ff == twc_pkg::PORT_HTTPS;
      else port_hit_in = pchain[PORT_SLOTS];
   end
   always_ff @(posedge clock) begin
      ahit_ff <= bchain[BLOCK_ENTRIES];
      phit_ff <= port_hit_in;
   end

   // Parser next state.
   logic [15:0] off_in, kind_in, dport_in;
   logic [2:0]  phase_in;
   logic [5:0]  iph_in;
   logic [7:0]  proto_in, ob;
   logic [3:0]  doff_in;
   logic [63:0] ahi_in, alo_in;
   logic        clamp_in;
   logic        clamp_out;
   logic [15:0] tstart, rel;
   logic [16:0] need20, needd;
   logic [7:0]  b;
   assign b = req_data.byte_value;
   assign tstart = 16'(twc_pkg::ETH_HDR) + 16'(iph_ff);
   assign rel    = off_ff - tstart;
   assign need20 = 17'(tstart) + 17'(twc_pkg::MIN_HDR);
   assign needd  = 17'(tstart) + {11'd0, doff_ff, 2'b00};

   always_comb begin
      off_in = off_ff; phase_in = phase_ff; kind_in = kind_ff; iph_in = iph_ff;
      proto_in = proto_ff; doff_in = doff_ff; ahi_in = ahi_ff; alo_in = alo_ff;
      dport_in = dport_ff; clamp_in = clamp_ff; ob = b;
      case (phase_ff)
         twc_pkg::PH_ETH: begin
            if (off_ff == 16'd12 || off_ff == 16'd13) kind_in = {kind_ff[7:0], b};
            if (off_ff == 16'd13) begin
               if (kind_in == twc_pkg::KIND_V4) phase_in = twc_pkg::PH_V4;
               else if (kind_in == twc_pkg::KIND_V6) begin
                  phase_in = twc_pkg::PH_V6;
                  iph_in = twc_pkg::V6_HDR;
               end else phase_in = twc_pkg::PH_PASS;
            end
         end
         twc_pkg::PH_V4: begin
            if (off_ff == 16'd14) begin
               iph_in = {b[3:0], 2'b00};
               if (7'(iph_in) < twc_pkg::MIN_HDR) phase_in = twc_pkg::PH_PASS;
            end else if (off_ff == 16'd23) proto_in = b;
            else if (off_ff >= 16'd30 && off_ff <= 16'd33) begin
               ahi_in = {ahi_ff[55:0], alo_ff[63:56]};
               alo_in = {alo_ff[55:0], b};
            end
            if (phase_in == twc_pkg::PH_V4 && off_ff == 16'(twc_pkg::ETH_HDR) + 16'(iph_in) - 16'd1)
               phase_in = twc_pkg::PH_TCP;
         end
         twc_pkg::PH_V6: begin
            if (off_ff == 16'd20) proto_in = b;
            else if (off_ff >= 16'd38 && off_ff <= 16'd53) begin
               ahi_in = {ahi_ff[55:0], alo_ff[63:56]};
               alo_in = {alo_ff[55:0], b};
            end
            if (off_ff == 16'd53) phase_in = twc_pkg::PH_TCP;
         end
         twc_pkg::PH_TCP: begin
            if (rel == 16'd2 || rel == 16'd3) dport_in = {dport_ff[7:0], b};
            else if (rel == 16'd12) doff_in = b[7:4];
            else if (rel == 16'd14) begin
               clamp_in = proto_ff == twc_pkg::PROTO_TCP
                  && need20 <= {1'b0, req_data.frame_length}
                  && doff_ff >= twc_pkg::MIN_DOFF
                  && needd <= {1'b0, req_data.frame_length}
                  && ahit_ff && phit_ff;
               if (clamp_in) ob = 8'h00;
            end else if (rel == 16'd15) begin
               if (clamp_ff) ob = 8'h01;
               phase_in = twc_pkg::PH_PASS;
            end
         end
         default: ;
      endcase
      // The flag reported with this byte is taken before the end of frame clears it.
      clamp_out = clamp_in;
      if (req_data.frame_end) begin
         off_in = 16'd0; phase_in = twc_pkg::PH_ETH; kind_in = 16'd0; iph_in = 6'd0;
         proto_in = 8'd0; doff_in = 4'd0; ahi_in = 64'd0; alo_in = 64'd0;
         dport_in = 16'd0; clamp_in = 1'b0;
      end else if (off_ff != 16'hFFFF) off_in = off_ff + 16'd1;
   end

   // Parser and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= 16'd0; phase_ff <= twc_pkg::PH_ETH; kind_ff <= 16'd0; iph_ff <= 6'd0;
         proto_ff <= 8'd0; doff_ff <= 4'd0; ahi_ff <= 64'd0; alo_ff <= 64'd0;
         dport_ff <= 16'd0; clamp_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         if (take && is_byte) begin
            off_ff <= off_in; phase_ff <= phase_in; kind_ff <= kind_in; iph_ff <= iph_in;
            proto_ff <= proto_in; doff_ff <= doff_in; ahi_ff <= ahi_in; alo_ff <= alo_in;
            dport_ff <= dport_in; clamp_ff <= clamp_in;
         end
         if (take) rsp_valid_ff <= is_byte;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      if (take && is_byte) begin
         rsp_ff.out_byte <= ob;
         rsp_ff.out_end  <= req_data.frame_end;
         rsp_ff.clamped  <= clamp_out;
      end
   end

endmodule

// File: hdl/twc_block_cell.sv
// One blocklist slot: an IPv4 entry and an IPv6 entry, compared against the key.
// The match flag ripples as an OR chain and is registered at the end of the chain.
// The compare sees the entry as it stands after a write in the same cycle.
module twc_block_cell #(
   parameter int SLOT = 0,
   parameter int IW   = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  twc_pkg::tbl_wr_type wr,
   input  twc_pkg::key_type   key,
   input  logic               hit_prev,
   output logic               hit_next
);

   logic        v4_val_ff;
   logic [31:0] v4_addr_ff;
   logic        v6_val_ff;
   logic [63:0] v6_hi_ff;
   logic [63:0] v6_lo_ff;
   logic        v4_val_in;
   logic [31:0] v4_addr_in;
   logic        v6_val_in;
   logic [63:0] v6_hi_in;
   logic [63:0] v6_lo_in;
   logic        sel;

   assign sel = (wr.index == IW'(SLOT));

   // Next entry contents, taking a write in this cycle into account.
   assign v4_val_in  = (wr.wr_v4 && sel) ? wr.valid : v4_val_ff;
   assign v4_addr_in = (wr.wr_v4 && sel) ? wr.addr_lo[31:0] : v4_addr_ff;
   assign v6_val_in  = (wr.wr_v6 && sel) ? wr.valid : v6_val_ff;
   assign v6_hi_in   = (wr.wr_v6 && sel) ? wr.addr_hi : v6_hi_ff;
   assign v6_lo_in   = (wr.wr_v6 && sel) ? wr.addr_lo : v6_lo_ff;

   // Entry storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_val_ff <= 1'b0;
         v6_val_ff <= 1'b0;
      end else begin
         v4_val_ff <= v4_val_in;
         v6_val_ff <= v6_val_in;
      end
      v4_addr_ff <= v4_addr_in;
      v6_hi_ff   <= v6_hi_in;
      v6_lo_ff   <= v6_lo_in;
   end

   // Compare and merge with the neighbor's result.
   always_comb begin
      if (key.is_v4) hit_next = hit_prev | (v4_val_in && v4_addr_in == key.addr_lo[31:0]);
      else hit_next = hit_prev | (v6_val_in && v6_hi_in == key.addr_hi
                                  && v6_lo_in == key.addr_lo);
   end

endmodule

// File: hdl/twc_port_cell.sv
// One protected-port slot; it matches only while its slot number is in use.
// The compare sees the slot as it stands after a write in the same cycle.
module twc_port_cell #(
   parameter int SLOT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  twc_pkg::tbl_wr_type wr,
   input  twc_pkg::key_type   key,
   input  logic [3:0]         port_count,
   input  logic               hit_prev,
   output logic               hit_next
);

   logic [15:0] port_ff;
   logic [15:0] port_in;

   assign port_in = (wr.wr_port && wr.index == 6'(SLOT)) ? wr.port : port_ff;

   always_ff @(posedge clock) begin
      if (reset) port_ff <= 16'd0;
      else port_ff <= port_in;
   end

   assign hit_next = hit_prev | ((7'(SLOT) < {3'b000, port_count}) && port_in == key.port);

endmodule

// File: hdl/twc_checker.sv
// Port-level checks on the filter.
module twc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input twc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input twc_pkg::rsp_type rsp_data
);

   // A stalled result word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed under stall");

   // A table write yields no result word.
   a_nowr: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command != twc_pkg::CMD_BYTE |=> !rsp_valid)
      else $error("table write produced a word");

   // A packet byte yields a result word carrying its end flag.
   a_byte: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command == twc_pkg::CMD_BYTE
      |=> rsp_valid && rsp_data.out_end == $past(req_data.frame_end))
      else $error("packet byte lost");

   // The input is always ready while the output is empty.
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

endmodule

bind tcp_window_clamp_filter twc_checker u_twc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_data(rsp_data));
